// ===== sv/range_threshold_count_store_unit_assert.svh =====
// Assertion macros used by the checker module of the range threshold count store
`ifndef RANGE_THRESHOLD_COUNT_STORE_UNIT_ASSERT_SVH
`define RANGE_THRESHOLD_COUNT_STORE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define RTCS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("range threshold count store: check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define RTCS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("range threshold count store: check failed");

`endif

// ===== sv/rtcs_pkg.sv =====
// Shared types and constants of the range threshold count store
`default_nettype none
package rtcs_pkg;

  localparam int DEPTH_DEF = 65536;
  localparam int LANES_DEF = 8;

  localparam int DATA_W  = 32;
  localparam int FIRST_W = 16;
  localparam int END_W   = 17;
  localparam int COUNT_W = 17;

  localparam logic KIND_QUERY = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_WRITE,
    ST_WALK,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic wr;
    logic rd;
  } mem_cmd_t;

  typedef struct packed {
    logic               valid;
    logic [COUNT_W-1:0] count;
  } res_t;

endpackage
`default_nettype wire

// ===== sv/rtcs_mem.sv =====
// Word-wide value memory with single-lane writes and a registered word read
`default_nettype none
module rtcs_mem #(
  parameter int WORDS = 8192,
  parameter int LANES = 8,
  parameter int WAW   = 13,
  parameter int LW    = 3
) (
  input  wire logic                                    clk,
  input  wire rtcs_pkg::mem_cmd_t                      cmd,
  input  wire logic [WAW-1:0]                          addr,
  input  wire logic [LW-1:0]                           lane,
  input  wire logic [rtcs_pkg::DATA_W-1:0]             wdata,
  output logic      [LANES-1:0][rtcs_pkg::DATA_W-1:0]  rdata
);

  logic [LANES-1:0][rtcs_pkg::DATA_W-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[addr][lane] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire

// ===== sv/rtcs_ctrl.sv =====
// Item sequencer: index split, memory walk, lane compare and count accumulate
`default_nettype none
module rtcs_ctrl #(
  parameter int DEPTH = rtcs_pkg::DEPTH_DEF,
  parameter int LANES = rtcs_pkg::LANES_DEF,
  parameter int WAW   = 13,
  parameter int LW    = 3
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    in_valid,
  output logic                                         in_stall,
  input  wire logic                                    kind,
  input  wire logic [rtcs_pkg::FIRST_W-1:0]            first_index,
  input  wire logic [rtcs_pkg::END_W-1:0]              end_index,
  input  wire logic signed [rtcs_pkg::DATA_W-1:0]      value,
  output rtcs_pkg::mem_cmd_t                           mem_cmd,
  output logic [WAW-1:0]                               mem_addr,
  output logic [LW-1:0]                                mem_lane,
  output logic [rtcs_pkg::DATA_W-1:0]                  mem_wdata,
  input  wire logic [LANES-1:0][rtcs_pkg::DATA_W-1:0]  mem_rdata,
  output rtcs_pkg::res_t                               res,
  input  wire logic                                    res_take
);

  localparam int WORDS = (DEPTH + LANES - 1) / LANES;
  localparam int SPAN  = WORDS * LANES;
  localparam int IW    = ($clog2(SPAN + 1) > rtcs_pkg::END_W) ?
                         $clog2(SPAN + 1) : rtcs_pkg::END_W;
  localparam int PW    = $clog2(LANES + 1);
  localparam int FW    = rtcs_pkg::FIRST_W;
  localparam int CW    = rtcs_pkg::COUNT_W;
  localparam int DSH   = FW + $clog2(LANES);
  localparam int PRW   = FW + DSH + 1;
  localparam int RECIP = ((1 << DSH) + LANES - 1) / LANES;

  rtcs_pkg::state_t state, state_next;

  logic                           is_write;
  logic [IW-1:0]                  lo;
  logic [IW-1:0]                  hi;
  logic [rtcs_pkg::DATA_W-1:0]    thr;
  logic [FW-1:0]                  quot;
  logic                           step;
  logic [WAW-1:0]                 addr;
  logic [LW-1:0]                  lane;
  logic [IW-1:0]                  base;
  logic [IW-1:0]                  base1;
  logic                           v1;
  logic                           v2;
  logic [LANES-1:0]               hits;
  logic [LANES-1:0]               hits_next;
  logic [PW-1:0]                  pop;
  logic [CW-1:0]                  count;

  logic                           accept;
  logic [IW-1:0]                  lo_in;
  logic [IW-1:0]                  end_ext;
  logic [IW-1:0]                  hi_in;
  logic                           div_last;
  logic                           issue_last;
  logic [PRW-1:0]                 recip_prod;
  logic [IW-1:0]                  word_base;

  assign lo_in      = IW'(first_index);
  assign end_ext    = IW'(end_index);
  assign hi_in      = (end_ext > IW'(DEPTH)) ? IW'(DEPTH) : end_ext;
  assign div_last   = step;
  assign issue_last = ((base + IW'(LANES)) >= hi);

  // word index by reciprocal multiply, exact over the whole index range
  assign recip_prod = PRW'(lo[FW-1:0]) * PRW'(RECIP);
  assign word_base  = IW'(quot) * IW'(LANES);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rtcs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_stall    = 1'b1;
    accept      = 1'b0;
    mem_cmd.wr  = 1'b0;
    mem_cmd.rd  = 1'b0;
    case (state)
      rtcs_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        accept   = in_valid;
        if (in_valid) begin
          if (kind == rtcs_pkg::KIND_WRITE) begin
            if (lo_in < IW'(DEPTH)) begin
              state_next = rtcs_pkg::ST_DIV;
            end
          end else if (lo_in < hi_in) begin
            state_next = rtcs_pkg::ST_DIV;
          end else begin
            state_next = rtcs_pkg::ST_DONE;
          end
        end
      end
      rtcs_pkg::ST_DIV: begin
        if (div_last) begin
          state_next = is_write ? rtcs_pkg::ST_WRITE : rtcs_pkg::ST_WALK;
        end
      end
      rtcs_pkg::ST_WRITE: begin
        mem_cmd.wr = 1'b1;
        state_next = rtcs_pkg::ST_IDLE;
      end
      rtcs_pkg::ST_WALK: begin
        mem_cmd.rd = 1'b1;
        if (issue_last) begin
          state_next = rtcs_pkg::ST_DRAIN;
        end
      end
      rtcs_pkg::ST_DRAIN: begin
        if (!v1 && !v2) begin
          state_next = rtcs_pkg::ST_DONE;
        end
      end
      rtcs_pkg::ST_DONE: begin
        if (res_take) begin
          state_next = rtcs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rtcs_pkg::ST_IDLE;
      end
    endcase
  end

  // lane compare against range bounds and threshold
  always_comb begin
    logic [IW-1:0] idx;
    idx = '0;
    for (int l = 0; l < LANES; l++) begin
      idx = base1 + IW'(l);
      hits_next[l] = v1 && (idx >= lo) && (idx < hi) &&
                     ($signed(mem_rdata[l]) >= $signed(thr));
    end
  end

  always_comb begin
    pop = '0;
    for (int l = 0; l < LANES; l++) begin
      pop = pop + PW'(hits[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= mem_cmd.rd;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    base1 <= base;
    hits  <= hits_next;
    if (accept) begin
      is_write <= (kind == rtcs_pkg::KIND_WRITE);
      lo       <= lo_in;
      hi       <= hi_in;
      thr      <= value;
      step     <= 1'b0;
      count    <= '0;
    end else if (v2) begin
      count <= count + CW'(pop);
    end
    if (state == rtcs_pkg::ST_DIV) begin
      step <= 1'b1;
      quot <= recip_prod[DSH +: FW];
      if (div_last) begin
        addr <= WAW'(quot);
        lane <= LW'(lo - word_base);
        base <= word_base;
      end
    end
    if (state == rtcs_pkg::ST_WALK) begin
      addr <= addr + WAW'(1);
      base <= base + IW'(LANES);
    end
  end

  assign mem_addr  = addr;
  assign mem_lane  = lane;
  assign mem_wdata = thr;
  assign res.valid = (state == rtcs_pkg::ST_DONE);
  assign res.count = count;

endmodule
`default_nettype wire

// ===== sv/range_threshold_count_store_unit.sv =====
// Top level of the range threshold count store with its result register
`default_nettype none
// Keeps DEPTH signed 32-bit values in one memory of LANES values per word.
// A write item stores value at first_index and gives no result; a query
// item returns how many entries in [first_index, end_index) are at or above
// value (signed), with end_index clipped to DEPTH and an empty range giving
// zero. Every write with an in-range index and every non-empty query first
// splits its index into word and lane with a registered reciprocal multiply;
// a query then reads each memory word that the range touches, one word read
// per cycle through the memory's single port. An empty query goes straight
// to its result and a write beyond the store is dropped. One item is worked
// at a time; a finished count waits in the output register while the next
// item runs, and a query whose count finds that register still stalled
// waits for it.
// Reading an entry that was never written gives an undefined count.
module range_threshold_count_store_unit #(
  parameter int DEPTH = rtcs_pkg::DEPTH_DEF,
  parameter int LANES = rtcs_pkg::LANES_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic                                 kind,
  input  wire logic [rtcs_pkg::FIRST_W-1:0]         first_index,
  input  wire logic [rtcs_pkg::END_W-1:0]           end_index,
  input  wire logic signed [rtcs_pkg::DATA_W-1:0]   value,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [rtcs_pkg::COUNT_W-1:0]              count
);

  localparam int WORDS = (DEPTH + LANES - 1) / LANES;
  localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int LW    = (LANES > 1) ? $clog2(LANES) : 1;

  rtcs_pkg::mem_cmd_t                     mem_cmd;
  logic [WAW-1:0]                         mem_addr;
  logic [LW-1:0]                          mem_lane;
  logic [rtcs_pkg::DATA_W-1:0]            mem_wdata;
  logic [LANES-1:0][rtcs_pkg::DATA_W-1:0] mem_rdata;
  rtcs_pkg::res_t                         res;
  logic                                   res_take;

  rtcs_ctrl #(
    .DEPTH (DEPTH),
    .LANES (LANES),
    .WAW   (WAW),
    .LW    (LW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .first_index (first_index),
    .end_index   (end_index),
    .value       (value),
    .mem_cmd     (mem_cmd),
    .mem_addr    (mem_addr),
    .mem_lane    (mem_lane),
    .mem_wdata   (mem_wdata),
    .mem_rdata   (mem_rdata),
    .res         (res),
    .res_take    (res_take)
  );

  rtcs_mem #(
    .WORDS (WORDS),
    .LANES (LANES),
    .WAW   (WAW),
    .LW    (LW)
  ) u_mem (
    .clk   (clk),
    .cmd   (mem_cmd),
    .addr  (mem_addr),
    .lane  (mem_lane),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  assign res_take = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid && res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_take) begin
      count <= res.count;
    end
  end

endmodule
`default_nettype wire

// ===== sv/rtcs_chk.sv =====
// Port-level checker of the range threshold count store and its bind
`default_nettype none
`include "range_threshold_count_store_unit_assert.svh"
module rtcs_chk (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic                          kind,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [rtcs_pkg::COUNT_W-1:0]  count
);

  // hold a stalled count
  `RTCS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(count))

  // a count never exceeds the largest range
  `RTCS_ASSERT_NOW(a_count_max, out_valid, !(count[16] && (count[15:0] != 16'd0)))

  // a query keeps the input side busy after it is taken
  `RTCS_ASSERT_NEXT(a_query_busy, in_valid && !in_stall && (kind == rtcs_pkg::KIND_QUERY), in_stall)

  // a new result comes only from a busy sequencer
  `RTCS_ASSERT_NOW(a_result_src, $rose(out_valid), $past(in_stall))

endmodule

bind range_threshold_count_store_unit rtcs_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .kind      (kind),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .count     (count)
);
`default_nettype wire

// ===== tb/range_threshold_count_store_unit_tb.sv =====
// Testbench for range_threshold_count_store_unit: random writes and range count queries
`timescale 1ns / 1ps
`default_nettype none
module range_threshold_count_store_unit_tb;

  localparam int DEPTH = rtcs_pkg::DEPTH_DEF;
  localparam int END_MAX = (1 << rtcs_pkg::END_W) - 1;

  class count_scoreboard;
    logic [rtcs_pkg::DATA_W-1:0] stored [int];
    logic [rtcs_pkg::COUNT_W-1:0] awaited [$];
    int errors;
    int checked;

    function new();
      errors = 0;
      checked = 0;
    endfunction

    function void note_item(logic k, logic [rtcs_pkg::FIRST_W-1:0] f,
                            logic [rtcs_pkg::END_W-1:0] e,
                            logic [rtcs_pkg::DATA_W-1:0] v);
      int stop;
      int n;
      if (k == rtcs_pkg::KIND_WRITE) begin
        stored[f] = v;
        return;
      end
      stop = (e > DEPTH) ? DEPTH : int'(e);
      n = 0;
      for (int i = f; i < stop; i++) begin
        if ($signed(stored[i]) >= $signed(v)) n++;
      end
      awaited.push_back(n[rtcs_pkg::COUNT_W-1:0]);
    endfunction

    function void check_count(logic [rtcs_pkg::COUNT_W-1:0] got);
      logic [rtcs_pkg::COUNT_W-1:0] want;
      checked++;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected count, expected none, got %0d", $time, got);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (got !== want) begin
        $display("%0t: count mismatch, expected %0d, got %0d", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic kind;
  logic [rtcs_pkg::FIRST_W-1:0] first_index;
  logic [rtcs_pkg::END_W-1:0] end_index;
  logic signed [rtcs_pkg::DATA_W-1:0] value;
  logic out_valid;
  logic out_stall;
  logic [rtcs_pkg::COUNT_W-1:0] count;

  count_scoreboard sb;
  int n_items;
  int n_writes;
  int n_queries;
  int n_empty;
  int longest;
  bit burst_in;
  bit burst_out;
  int out_hold;
  int written_idx [$];

  range_threshold_count_store_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .kind(kind),
    .first_index(first_index),
    .end_index(end_index),
    .value(value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .count(count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("range_threshold_count_store_unit test failed");
    $finish;
  end

  always @(negedge clk) begin
    if (!rst) begin
      out_stall <= (out_hold > 0);
      if (out_hold > 0 && out_valid) out_hold--;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_count(count);
      out_hold = burst_out ? 0 : $urandom_range(0, 11);
    end
  end

  task automatic send_item(input logic k, input logic [rtcs_pkg::FIRST_W-1:0] f,
                           input logic [rtcs_pkg::END_W-1:0] e,
                           input logic [rtcs_pkg::DATA_W-1:0] v);
    int gap;
    gap = burst_in ? 0 : $urandom_range(0, 11);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    first_index <= f;
    end_index <= e;
    value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(k, f, e, v);
    n_items++;
  endtask

  task automatic write_at(input int idx, input logic [rtcs_pkg::DATA_W-1:0] v);
    if (!sb.stored.exists(idx)) written_idx.push_back(idx);
    send_item(rtcs_pkg::KIND_WRITE, idx[rtcs_pkg::FIRST_W-1:0],
              rtcs_pkg::END_W'($urandom_range(0, END_MAX)), v);
    n_writes++;
  endtask

  task automatic query(input int f, input int e, input logic [rtcs_pkg::DATA_W-1:0] thr);
    int stop;
    stop = (e > DEPTH) ? DEPTH : e;
    if (f >= stop) n_empty++;
    else if (stop - f > longest) longest = stop - f;
    send_item(rtcs_pkg::KIND_QUERY, f[rtcs_pkg::FIRST_W-1:0], e[rtcs_pkg::END_W-1:0], thr);
    n_queries++;
  endtask

  function automatic logic [rtcs_pkg::DATA_W-1:0] random_word();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 16) - 8;
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom();
    endcase
  endfunction

  task automatic query_written_run();
    int p;
    int reach;
    int lo;
    int hi;
    int e;
    logic [rtcs_pkg::DATA_W-1:0] thr;
    p = written_idx[$urandom_range(0, written_idx.size() - 1)];
    reach = ($urandom_range(0, 9) == 0) ? 300 : $urandom_range(0, 40);
    lo = p;
    while (lo > 0 && (p - lo) < reach && sb.stored.exists(lo - 1)) lo--;
    reach = ($urandom_range(0, 9) == 0) ? 300 : $urandom_range(0, 40);
    hi = p + 1;
    while (hi < DEPTH && (hi - p) < reach && sb.stored.exists(hi)) hi++;
    e = hi;
    if (hi == DEPTH && $urandom_range(0, 1)) e = $urandom_range(DEPTH, END_MAX);
    case ($urandom_range(0, 4))
      0: thr = sb.stored[$urandom_range(lo, hi - 1)];
      1: thr = sb.stored[$urandom_range(lo, hi - 1)] + ($urandom_range(0, 1) ? 1 : -1);
      2: thr = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: thr = random_word();
    endcase
    query(lo, e, thr);
  endtask

  initial begin : stimulus
    int r;
    int base;
    int len;
    int f;
    sb = new();
    n_items = 0;
    n_writes = 0;
    n_queries = 0;
    n_empty = 0;
    longest = 0;
    burst_in = 1'b0;
    burst_out = 1'b0;
    out_hold = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    kind = rtcs_pkg::KIND_QUERY;
    first_index = '0;
    end_index = '0;
    value = '0;
    out_stall = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_at(0, 32'h7FFF_FFFF);
    write_at(1, 32'h8000_0000);
    write_at(2, 32'h0000_0000);
    write_at(3, 32'hFFFF_FFFF);
    write_at(4, 32'h0000_0001);
    write_at(65533, 32'd12345);
    write_at(65534, 32'h7FFF_FFFF);
    write_at(65535, 32'h8000_0000);
    query(0, 5, 32'h8000_0000);
    query(0, 5, 32'h7FFF_FFFF);
    query(0, 5, 32'h0000_0000);
    query(0, 5, 32'hFFFF_FFFF);
    query(1, 2, 32'h8000_0000);
    query(65535, END_MAX, 32'h8000_0000);
    query(65533, DEPTH, 32'h0000_0000);
    query(65534, DEPTH + 1, 32'h0000_0001);
    query(0, 0, 32'h0000_0000);
    query(5, 3, 32'h8000_0000);
    query(65535, 0, 32'h8000_0000);
    query(40000, 40000, 32'hFFFF_FFFF);
    query(65535, 65535, 32'h7FFF_FFFF);

    for (int i = 30000; i < 30256; i++) write_at(i, random_word());

    while (n_items < 570) begin
      if (n_items % 40 == 0) begin
        burst_in = ($urandom_range(0, 3) == 0);
        burst_out = ($urandom_range(0, 3) == 0);
      end
      r = $urandom_range(0, 99);
      if (r < 25) begin
        case ($urandom_range(0, 3))
          0: base = $urandom_range(0, 200);
          1: base = $urandom_range(DEPTH - 200, DEPTH - 1);
          default: base = $urandom_range(0, DEPTH - 1);
        endcase
        len = $urandom_range(1, 16);
        for (int i = base; i < base + len && i < DEPTH; i++) write_at(i, random_word());
      end else if (r < 33) begin
        write_at(written_idx[$urandom_range(0, written_idx.size() - 1)], random_word());
      end else if (r < 90) begin
        query_written_run();
      end else begin
        f = $urandom_range(0, DEPTH - 1);
        query(f, $urandom_range(0, f), random_word());
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    $display("Ran %0d items: %0d writes, %0d count queries (%0d with empty range).",
             n_items, n_writes, n_queries, n_empty);
    $display("Checked %0d counts; longest range walked was %0d entries.", sb.checked, longest);
    if (sb.errors == 0) begin
      $display("range_threshold_count_store_unit test passed");
    end else begin
      $display("range_threshold_count_store_unit test failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
